FILE: hw/rtl/bqd_pkg.sv
package bqd_pkg;

   // Filter geometry.
   localparam int CHANNELS     = 2;
   localparam int SAMPLE_WIDTH = 24;

   // Coefficients are signed Q3.20, already divided by a0.
   localparam int COEF_WIDTH = 24;
   localparam int COEF_FRAC  = 20;
   localparam int NUM_COEFS  = 5;

   // Derived widths.
   localparam int CSR_INDEX_WIDTH = $clog2(NUM_COEFS);
   localparam int CHAN_IDX_WIDTH  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
   // Five products need three guard bits.
   localparam int ACC_WIDTH       = PROD_WIDTH + 3;
   localparam int QUANT_WIDTH     = ACC_WIDTH - COEF_FRAC;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic [CHAN_IDX_WIDTH-1:0]      chan_idx_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]     csr_index_type;

   // Coefficient register indexes.
   localparam csr_index_type CSR_COEF_FF0 = csr_index_type'(0);
   localparam csr_index_type CSR_COEF_FF1 = csr_index_type'(1);
   localparam csr_index_type CSR_COEF_FF2 = csr_index_type'(2);
   localparam csr_index_type CSR_COEF_FB1 = csr_index_type'(3);
   localparam csr_index_type CSR_COEF_FB2 = csr_index_type'(4);

   // Unity gain in Q3.20.
   localparam coef_type COEF_ONE = coef_type'(1 << COEF_FRAC);

   typedef struct packed {
      sample_type in_sample;
      logic       in_channel;
      logic       in_block_end;
   } req_payload_type;

   typedef struct packed {
      sample_type out_sample;
      logic       out_channel;
      logic       out_block_end;
   } rsp_payload_type;

   typedef struct packed {
      coef_type ff0;
      coef_type ff1;
      coef_type ff2;
      coef_type fb1;
      coef_type fb2;
   } coef_set_type;

   // Delay taps of one channel.
   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } taps_type;

endpackage

FILE: hw/rtl/bqd_mac.sv
module bqd_mac (
   input  bqd_pkg::sample_type   sample,
   input  bqd_pkg::taps_type     taps,
   input  bqd_pkg::coef_set_type coefs,
   output bqd_pkg::sample_type   result
);
   import bqd_pkg::*;

   logic signed [PROD_WIDTH-1:0]  prod_x0;
   logic signed [PROD_WIDTH-1:0]  prod_x1;
   logic signed [PROD_WIDTH-1:0]  prod_x2;
   logic signed [PROD_WIDTH-1:0]  prod_y1;
   logic signed [PROD_WIDTH-1:0]  prod_y2;
   logic signed [ACC_WIDTH-1:0]   acc;
   logic signed [ACC_WIDTH-1:0]   acc_rnd;
   logic signed [QUANT_WIDTH-1:0] quant;
   logic                          fits;

   // Five independent exact products.
   assign prod_x0 = coefs.ff0 * sample;
   assign prod_x1 = coefs.ff1 * taps.x1;
   assign prod_x2 = coefs.ff2 * taps.x2;
   assign prod_y1 = coefs.fb1 * taps.y1;
   assign prod_y2 = coefs.fb2 * taps.y2;

   // Exact sum of the products.
   assign acc = ACC_WIDTH'(prod_x0) + ACC_WIDTH'(prod_x1) + ACC_WIDTH'(prod_x2)
              + ACC_WIDTH'(prod_y1) + ACC_WIDTH'(prod_y2);

   // Round half up, then drop the fraction bits (floor).
   assign acc_rnd = acc + (ACC_WIDTH'(1) << (COEF_FRAC - 1));
   assign quant   = acc_rnd[ACC_WIDTH-1:COEF_FRAC];

   // The value fits when all bits above the sample sign bit equal the sign.
   assign fits = (quant[QUANT_WIDTH-1:SAMPLE_WIDTH-1] == '0) ||
                 (quant[QUANT_WIDTH-1:SAMPLE_WIDTH-1] == '1);

   // Clamp to the sample range.
   always_comb begin
      if (fits) begin
         result = quant[SAMPLE_WIDTH-1:0];
      end else if (quant[QUANT_WIDTH-1]) begin
         result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

endmodule

FILE: hw/rtl/biquad_df1_filter_top.sv
// Second-order IIR filter in direct form 1, with separate delay taps per channel.
// Samples enter on the req_ channel (valid/stall) with a channel tag and a
// block-end flag; filtered samples leave on the rsp_ channel in the same order,
// one result per input, with tag and flag copied through. Coefficients (Q3.20,
// divided by a0) are written through the csr_ port by index, by the user only
// while the filter is idle, which the block does not enforce; an index past the
// last coefficient is ignored. An accepted item passes through the input
// register and then the output register, whose valid bit drives rsp_valid.
// Throughput: one item per cycle while rsp_stall is low. The multiply-accumulate
// and the update of the channel's delay taps both happen between the input
// register and the output register, so consecutive items on the same channel
// see the previous output without any hazard wait.
// Reset (synchronous) empties both registers, sets the filter to unity gain
// pass-through and clears all delay taps to zero.
// When the receiver stalls, the output register holds its result; one more item
// can still be taken into the input register, after which req_stall rises.
module biquad_df1_filter_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bqd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bqd_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_wr_en,
   input  bqd_pkg::csr_index_type   csr_index,
   input  bqd_pkg::coef_type        csr_wr_data
);
   import bqd_pkg::*;

   coef_set_type    coef_ff;
   coef_set_type    coef_in;

   logic            s1_vld_ff;
   logic            s1_vld_in;
   req_payload_type s1_data_ff;

   logic            rsp_vld_ff;
   logic            rsp_vld_in;
   rsp_payload_type rsp_data_ff;

   sample_type      x1_ff [CHANNELS];
   sample_type      x2_ff [CHANNELS];
   sample_type      y1_ff [CHANNELS];
   sample_type      y2_ff [CHANNELS];

   logic            s1_load;
   logic            rsp_load;
   chan_idx_type    ch_idx;
   taps_type        taps;
   sample_type      y_value;

   // Coefficient writes by register index.
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_FF0: coef_in.ff0 = csr_wr_data;
            CSR_COEF_FF1: coef_in.ff1 = csr_wr_data;
            CSR_COEF_FF2: coef_in.ff2 = csr_wr_data;
            CSR_COEF_FB1: coef_in.fb1 = csr_wr_data;
            CSR_COEF_FB2: coef_in.fb2 = csr_wr_data;
            default:      coef_in     = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{ff0: COEF_ONE, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Handshake: the output register takes the input item when it is empty or
   // its result is being transferred out.
   assign rsp_load  = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !rsp_load;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      if (s1_load) begin
         s1_vld_in = 1'b1;
      end else if (rsp_load) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_vld_in = rsp_vld_ff;
      end else begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
   end

   // Select the channel's delay taps; a single channel always uses entry zero.
   assign ch_idx = (CHANNELS > 1) ? chan_idx_type'(s1_data_ff.in_channel) : '0;
   assign taps   = '{x1: x1_ff[ch_idx], x2: x2_ff[ch_idx],
                     y1: y1_ff[ch_idx], y2: y2_ff[ch_idx]};

   bqd_mac u_mac (
      .sample (s1_data_ff.in_sample),
      .taps   (taps),
      .coefs  (coef_ff),
      .result (y_value)
   );

   // Delay taps shift when the result is registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (rsp_load) begin
         x2_ff[ch_idx] <= x1_ff[ch_idx];
         x1_ff[ch_idx] <= s1_data_ff.in_sample;
         y2_ff[ch_idx] <= y1_ff[ch_idx];
         y1_ff[ch_idx] <= y_value;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= '{out_sample:    y_value,
                          out_channel:   s1_data_ff.in_channel,
                          out_block_end: s1_data_ff.in_block_end};
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/bqd_checker.sv
module bqd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input bqd_pkg::rsp_payload_type rsp_data
);

   // A stalled result stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the output empty, the input side never stalls.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output register empty");

   // A result appearing at an empty output comes from an earlier input transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without matching input transfer");

endmodule

bind biquad_df1_filter_top bqd_checker u_bqd_checker (.*);

FILE: test/biquad_df1_filter_checker.sv
module biquad_df1_filter_checker
   import bqd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  csr_index_type   csr_index,
   input  coef_type        csr_wr_data,
   output int              mismatch_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SAT_HIGH   = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LOW    = -(longint'(1) <<< (SAMPLE_WIDTH - 1));
   localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);
   // Lines printed before the log goes quiet; counting continues.
   localparam int     PRINT_LIMIT = 100;

   // Mirror of the coefficient registers and of every channel's delay taps.
   coef_set_type    coefs;
   taps_type        taps [CHANNELS];
   rsp_payload_type expected_samples [$];

   // Prints one line per mismatch, up to PRINT_LIMIT, and counts every one.
   task automatic report_mismatch(input string what,
                                  input logic signed [SAMPLE_WIDTH-1:0] got,
                                  input logic signed [SAMPLE_WIDTH-1:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count = mismatch_count + 1;
   endtask

   // Runs one sample through its channel's taps: exact products, round half
   // up to the sample grid, clamp, then shift the taps with the clamped value.
   function automatic rsp_payload_type filter_sample(input req_payload_type item);
      int              chan;
      longint          acc;
      longint          level;
      rsp_payload_type result;
      chan = int'(item.in_channel) % CHANNELS;
      acc = longint'($signed(coefs.ff0)) * longint'($signed(item.in_sample))
          + longint'($signed(coefs.ff1)) * longint'($signed(taps[chan].x1))
          + longint'($signed(coefs.ff2)) * longint'($signed(taps[chan].x2))
          + longint'($signed(coefs.fb1)) * longint'($signed(taps[chan].y1))
          + longint'($signed(coefs.fb2)) * longint'($signed(taps[chan].y2));
      level = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (level > SAT_HIGH) begin
         level = SAT_HIGH;
      end
      if (level < SAT_LOW) begin
         level = SAT_LOW;
      end
      taps[chan].x2 = taps[chan].x1;
      taps[chan].x1 = item.in_sample;
      taps[chan].y2 = taps[chan].y1;
      taps[chan].y1 = sample_type'(level);
      result.out_sample    = sample_type'(level);
      result.out_channel   = item.in_channel;
      result.out_block_end = item.in_block_end;
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         coefs     = '0;
         coefs.ff0 = COEF_ONE;
         foreach (taps[i]) begin
            taps[i] = '0;
         end
         expected_samples.delete();
      end else begin
         // User makes coefficient writes only when filter is idle; unchecked.
         if (csr_wr_en === 1'b1) begin
            case (csr_index)
               CSR_COEF_FF0: coefs.ff0 = csr_wr_data;
               CSR_COEF_FF1: coefs.ff1 = csr_wr_data;
               CSR_COEF_FF2: coefs.ff2 = csr_wr_data;
               CSR_COEF_FB1: coefs.fb1 = csr_wr_data;
               CSR_COEF_FB2: coefs.fb2 = csr_wr_data;
               default: ;
            endcase
         end
         // Each result transfer is matched against the oldest expectation.
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("result with none expected", rsp_data.out_sample, '0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.out_sample !== want.out_sample) begin
                  report_mismatch("out_sample", rsp_data.out_sample, want.out_sample);
               end
               if (rsp_data.out_channel !== want.out_channel) begin
                  report_mismatch("out_channel", sample_type'(rsp_data.out_channel),
                                  sample_type'(want.out_channel));
               end
               if (rsp_data.out_block_end !== want.out_block_end) begin
                  report_mismatch("out_block_end", sample_type'(rsp_data.out_block_end),
                                  sample_type'(want.out_block_end));
               end
            end
         end
         // Every accepted sample transfer yields exactly one filtered sample.
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            expected_samples.push_back(filter_sample(req_data));
         end
      end
      pending_count <= expected_samples.size();
   end

endmodule

FILE: test/tb_biquad_df1_filter_top.sv
module tb_biquad_df1_filter_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bqd_pkg::*;

   // Far beyond the slowest legal run.
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SEGMENTS      = 14;
   localparam int SEGMENT_ITEMS = 80;

   localparam int FIRST_UNMAPPED_INDEX = NUM_COEFS;
   localparam int LAST_INDEX           = (1 << CSR_INDEX_WIDTH) - 1;

   localparam coef_type   COEF_MAX   = coef_type'({1'b0, {(COEF_WIDTH-1){1'b1}}});
   localparam coef_type   COEF_MIN   = coef_type'({1'b1, {(COEF_WIDTH-1){1'b0}}});
   localparam coef_type   COEF_HALF  = coef_type'(1 << (COEF_FRAC - 1));
   localparam coef_type   COEF_ZERO  = coef_type'(0);
   localparam sample_type SAMPLE_MAX = sample_type'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam sample_type SAMPLE_MIN = sample_type'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});

   typedef enum int {
      COEFS_UNITY,
      COEFS_LOWPASS,
      COEFS_RANDOM,
      COEFS_GENTLE,
      COEFS_EXTREME,
      COEFS_NOTCH,
      COEFS_KINDS
   } coef_mix_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_wr_en   = 1'b0;
   csr_index_type   csr_index   = CSR_COEF_FF0;
   coef_type        csr_wr_data = '0;

   int mismatch_count;
   int pending_count;
   int req_idle_pct  = 18;
   int rsp_stall_pct = 70;
   int cycle_count   = 0;

   biquad_df1_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   biquad_df1_filter_checker filter_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_payload_type make_item(input sample_type sample, input logic chan,
                                                 input logic last);
      req_payload_type item;
      item.in_sample    = sample;
      item.in_channel   = chan;
      item.in_block_end = last;
      return item;
   endfunction

   // Mostly full-range samples, with quiet signals and rail values mixed in.
   function automatic sample_type random_sample();
      case ($urandom_range(19))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_type'(0);
         3: return sample_type'(-1);
         4, 5, 6: return sample_type'(int'($urandom_range(8191)) - 4096);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic coef_type random_coef(input coef_mix_type mix);
      case (mix)
         COEFS_GENTLE:  return coef_type'(int'($urandom_range(2 << COEF_FRAC)) -
                                          (1 << COEF_FRAC));
         COEFS_EXTREME: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
         default:       return coef_type'($urandom);
      endcase
   endfunction

   function automatic coef_set_type pick_coefs(input coef_mix_type mix);
      case (mix)
         COEFS_UNITY:
            return '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
         // Stable low-pass section.
         COEFS_LOWPASS:
            return '{coef_type'(70779), coef_type'(141558), coef_type'(70779),
                     coef_type'(1198522), coef_type'(-432852)};
         // Narrow notch with poles close to the unit circle.
         COEFS_NOTCH:
            return '{coef_type'(943718), coef_type'(-1887437), coef_type'(943718),
                     coef_type'(1876951), coef_type'(-849347)};
         default:
            return '{random_coef(mix), random_coef(mix), random_coef(mix),
                     random_coef(mix), random_coef(mix)};
      endcase
   endfunction

   // Offers one sample, idling first at the phase's rate, and holds it until
   // the transfer happens.
   task automatic send_sample(input req_payload_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_payload_type'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Stops offering samples and waits until every result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_coef(input csr_index_type index, input coef_type value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   // Loads all five coefficients while idle, plus one write to an unmapped index
   // that the filter must ignore.
   task automatic load_coefs(input coef_set_type coefs);
      wait_idle();
      put_coef(CSR_COEF_FF0, coefs.ff0);
      put_coef(CSR_COEF_FF1, coefs.ff1);
      put_coef(CSR_COEF_FF2, coefs.ff2);
      put_coef(CSR_COEF_FB1, coefs.fb1);
      put_coef(CSR_COEF_FB2, coefs.fb2);
      if (FIRST_UNMAPPED_INDEX <= LAST_INDEX) begin
         put_coef(csr_index_type'($urandom_range(LAST_INDEX, FIRST_UNMAPPED_INDEX)),
                  coef_type'($urandom));
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Unity gain out of reset: rails, zero and one LSB pass straight through.
      send_sample(make_item(SAMPLE_MAX, 1'b0, 1'b0));
      send_sample(make_item(SAMPLE_MIN, 1'b1, 1'b1));
      send_sample(make_item(sample_type'(0), 1'b0, 1'b0));
      send_sample(make_item(sample_type'(-1), 1'b1, 1'b0));
      send_sample(make_item(sample_type'(1), 1'b0, 1'b1));

      // Extreme coefficients drive the sum past both rails.
      load_coefs('{COEF_MAX, COEF_MIN, COEF_ONE, COEF_ZERO, COEF_ZERO});
      send_sample(make_item(SAMPLE_MAX, 1'b0, 1'b0));
      send_sample(make_item(SAMPLE_MIN, 1'b0, 1'b0));
      send_sample(make_item(sample_type'(-1), 1'b1, 1'b0));
      send_sample(make_item(SAMPLE_MAX, 1'b1, 1'b1));

      // Half gain puts odd inputs exactly on the rounding midpoint.
      load_coefs('{COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
      send_sample(make_item(sample_type'(1), 1'b0, 1'b0));
      send_sample(make_item(sample_type'(-1), 1'b0, 1'b0));
      send_sample(make_item(sample_type'(3), 1'b1, 1'b0));
      send_sample(make_item(sample_type'(-3), 1'b1, 1'b1));

      // Extreme feedback: the clamped output must be what re-enters the taps.
      load_coefs('{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_MAX, COEF_MIN});
      repeat (5) begin
         send_sample(make_item(sample_type'(1000), 1'b0, 1'b0));
      end
      send_sample(make_item(sample_type'(1000), 1'b0, 1'b1));

      // Random samples in segments, each loading a coefficient set chosen by its
      // number, and three phases of the run each with its own idling pattern.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 5) begin
            req_idle_pct  = 70;
            rsp_stall_pct = 18;
         end else if (seg == 10) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         load_coefs(pick_coefs(coef_mix_type'(seg % COEFS_KINDS)));
         repeat (SEGMENT_ITEMS) begin
            send_sample(make_item(random_sample(), 1'($urandom_range(1)),
                                  $urandom_range(15) == 0));
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/bqd_pkg.sv
hw/rtl/bqd_mac.sv
hw/rtl/biquad_df1_filter_top.sv
hw/rtl/bqd_checker.sv
test/biquad_df1_filter_checker.sv
test/tb_biquad_df1_filter_top.sv
